// ----- design/rswa_pkg.sv -----
// shared types, constants and register indexes for the range sensor window average
package rswa_pkg;

    // distance and magnetic sample width
    localparam int DATA_W = 16;

    // default number of samples in each distance window
    localparam int WINDOW_DEPTH_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W = 1;

    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_CLAMP_TOP    = 1'd0;
    localparam t_cfg_idx REG_CLAMP_BOTTOM = 1'd1;

    // register reset values
    localparam t_data CLAMP_TOP_RST    = 16'd4000;
    localparam t_data CLAMP_BOTTOM_RST = 16'd20;

endpackage

// ----- design/rswa_cell.sv -----
// one window cell: holds a clamped sample and passes it to the next cell
module rswa_cell
    import rswa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_data i_d,
    output t_data o_q
);

    t_data r_q;

    // sample moves one cell down on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- design/rswa_window.sv -----
// row of window cells for one distance channel with its running sum
module rswa_window
    import rswa_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    parameter int SUM_W = DATA_W + $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  t_data            i_sample,
    output logic [SUM_W-1:0] o_sum_next
);

    t_data            w_q [DEPTH];
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    // chain of cells, newest sample enters at cell zero
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            rswa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_d     (i_sample),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            rswa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_d     (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    // running sum: add the new sample, drop the one leaving the last cell
    assign n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(w_q[DEPTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_next = n_sum;

endmodule

// ----- design/rswa_mean.sv -----
// window mean by reciprocal multiply, registered product
module rswa_mean
    import rswa_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    parameter int SUM_W = DATA_W + $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SUM_W-1:0] i_sum,
    output t_data            o_mean
);

    // floor(x / DEPTH) == (x * ceil(2^S / DEPTH)) >> S for every x below 2^SUM_W
    localparam int          LOG_D  = $clog2(DEPTH);
    localparam int          SHIFT  = SUM_W + LOG_D;
    localparam int          MUL_W  = SUM_W + 1;
    localparam int          PROD_W = SUM_W + MUL_W;
    localparam logic [63:0] K_ONE  = 64'd1 << SHIFT;
    localparam logic [63:0] K_RECIP = (K_ONE + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [MUL_W-1:0] K_MUL = K_RECIP[MUL_W-1:0];

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(K_MUL);
        end
    end

    assign o_mean = r_prod[SHIFT +: DATA_W];

endmodule

// ----- design/range_sensor_window_average.sv -----
// top level: clamped distance window average with magnetic line split
//
// Each accepted transfer carries two distances and two magnetic readings and
// yields one result. Distances are clamped to the configured band and shifted
// into a row of WINDOW_DEPTH cells per side; a running sum tracks each row.
// Until WINDOW_DEPTH samples have arrived the clamped value is returned with
// averaged low; from then on the truncated window mean is returned. A new item
// is taken every clock cycle unless o_stall is high. Behind the input transfer,
// one stage registers the running sum, the next registers the
// reciprocal multiply that forms the mean. Configuration writes take effect on
// the next input transfer and have no wait state.
module range_sensor_window_average
    import rswa_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // configuration write port
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_index,
    input  t_data    i_cfg_data,
    // input channel
    input  logic     i_valid,
    output logic     o_stall,
    input  t_data    i_sonar_left_mm,
    input  t_data    i_sonar_right_mm,
    input  t_data    i_mag_left,
    input  t_data    i_mag_right,
    // output channel
    output logic     o_valid,
    input  logic     i_stall,
    output t_data    o_dist_left_mm,
    output t_data    o_dist_right_mm,
    output logic     o_averaged,
    output t_data    o_mag_left_level,
    output logic     o_mag_left_outside,
    output t_data    o_mag_right_level,
    output logic     o_mag_right_outside
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] K_DEPTH = CNT_W'(WINDOW_DEPTH);

    function automatic t_data clamp_band(input t_data v, input t_data top, input t_data bot);
        t_data c;
        c = v;
        if (c >= top) begin
            c = top;
        end
        if (c <= bot) begin
            c = bot;
        end
        return c;
    endfunction

    function automatic t_data mag_level(input t_data v);
        return v[DATA_W-1] ? t_data'(~v + 1'b1) : v;
    endfunction

    t_data            r_clamp_top;
    t_data            r_clamp_bottom;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             w_accept_in;
    logic             w_move12;
    logic             w_s1_ready;
    logic             w_s2_ready;
    t_data            w_clamp_l;
    t_data            w_clamp_r;
    logic [SUM_W-1:0] w_sum_l;
    logic [SUM_W-1:0] w_sum_r;
    t_data            w_mean_l;
    t_data            w_mean_r;

    // stage one
    logic             r_v1;
    logic [SUM_W-1:0] r_s1_sum_l;
    logic [SUM_W-1:0] r_s1_sum_r;
    t_data            r_s1_clamp_l;
    t_data            r_s1_clamp_r;
    logic             r_s1_avg;
    t_data            r_s1_mag_l;
    t_data            r_s1_mag_r;
    logic             r_s1_out_l;
    logic             r_s1_out_r;

    // stage two (output register)
    logic             r_v2;
    t_data            r_s2_clamp_l;
    t_data            r_s2_clamp_r;
    logic             r_s2_avg;
    t_data            r_s2_mag_l;
    t_data            r_s2_mag_r;
    logic             r_s2_out_l;
    logic             r_s2_out_r;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_top    <= CLAMP_TOP_RST;
            r_clamp_bottom <= CLAMP_BOTTOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CLAMP_TOP:    r_clamp_top    <= i_cfg_data;
                REG_CLAMP_BOTTOM: r_clamp_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign w_s2_ready  = !r_v2 || !i_stall;
    assign w_s1_ready  = !r_v1 || w_s2_ready;
    assign w_move12    = r_v1 && w_s2_ready;
    assign o_stall     = !w_s1_ready;
    assign w_accept_in = i_valid && w_s1_ready;

    // clamp both distances
    assign w_clamp_l = clamp_band(i_sonar_left_mm, r_clamp_top, r_clamp_bottom);
    assign w_clamp_r = clamp_band(i_sonar_right_mm, r_clamp_top, r_clamp_bottom);

    // sample count saturates at the window depth
    assign n_count = (r_count == K_DEPTH) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept_in) begin
            r_count <= n_count;
        end
    end

    // window rows
    rswa_window #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_window_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (w_accept_in),
        .i_sample   (w_clamp_l),
        .o_sum_next (w_sum_l)
    );

    rswa_window #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_window_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (w_accept_in),
        .i_sample   (w_clamp_r),
        .o_sum_next (w_sum_r)
    );

    // stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_accept_in) begin
            r_v1 <= 1'b1;
        end else if (w_move12) begin
            r_v1 <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (w_accept_in) begin
            r_s1_sum_l   <= w_sum_l;
            r_s1_sum_r   <= w_sum_r;
            r_s1_clamp_l <= w_clamp_l;
            r_s1_clamp_r <= w_clamp_r;
            r_s1_avg     <= (n_count == K_DEPTH);
            r_s1_mag_l   <= mag_level(i_mag_left);
            r_s1_mag_r   <= mag_level(i_mag_right);
            r_s1_out_l   <= i_mag_left[DATA_W-1];
            r_s1_out_r   <= i_mag_right[DATA_W-1];
        end
    end

    // mean units register their product alongside the output register
    rswa_mean #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_mean_l (
        .i_clk  (i_clk),
        .i_en   (w_move12),
        .i_sum  (r_s1_sum_l),
        .o_mean (w_mean_l)
    );

    rswa_mean #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_mean_r (
        .i_clk  (i_clk),
        .i_en   (w_move12),
        .i_sum  (r_s1_sum_r),
        .o_mean (w_mean_r)
    );

    // stage two valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_move12) begin
            r_v2 <= 1'b1;
        end else if (!i_stall) begin
            r_v2 <= 1'b0;
        end
    end

    // stage two payload
    always_ff @(posedge i_clk) begin
        if (w_move12) begin
            r_s2_clamp_l <= r_s1_clamp_l;
            r_s2_clamp_r <= r_s1_clamp_r;
            r_s2_avg     <= r_s1_avg;
            r_s2_mag_l   <= r_s1_mag_l;
            r_s2_mag_r   <= r_s1_mag_r;
            r_s2_out_l   <= r_s1_out_l;
            r_s2_out_r   <= r_s1_out_r;
        end
    end

    // result fields
    assign o_valid             = r_v2;
    assign o_dist_left_mm      = r_s2_avg ? w_mean_l : r_s2_clamp_l;
    assign o_dist_right_mm     = r_s2_avg ? w_mean_r : r_s2_clamp_r;
    assign o_averaged          = r_s2_avg;
    assign o_mag_left_level    = r_s2_mag_l;
    assign o_mag_left_outside  = r_s2_out_l;
    assign o_mag_right_level   = r_s2_mag_r;
    assign o_mag_right_outside = r_s2_out_r;

endmodule

// ----- test/range_sensor_window_average_checker.sv -----
// checker for range_sensor_window_average: watches both channels, predicts each result, compares
module range_sensor_window_average_checker
    import rswa_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // configuration write port
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_index,
    input  t_data    i_cfg_data,
    // input channel
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_data    i_sonar_left_mm,
    input  t_data    i_sonar_right_mm,
    input  t_data    i_mag_left,
    input  t_data    i_mag_right,
    // output channel
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_data    i_dist_left_mm,
    input  t_data    i_dist_right_mm,
    input  logic     i_averaged,
    input  t_data    i_mag_left_level,
    input  logic     i_mag_left_outside,
    input  t_data    i_mag_right_level,
    input  logic     i_mag_right_outside,
    // status for the testbench top
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_data dist_left;
        t_data dist_right;
        logic  averaged;
        t_data mag_left_level;
        logic  mag_left_outside;
        t_data mag_right_level;
        logic  mag_right_outside;
    } t_sensor_result;

    // predictor state: band registers and both distance rings
    t_data          band_top;
    t_data          band_bottom;
    t_data          left_ring  [WINDOW_DEPTH];
    t_data          right_ring [WINDOW_DEPTH];
    int             ring_slot;
    int             fill_count;
    t_sensor_result expected_results [$];
    int             mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    // top limit first, then bottom limit, so the bottom wins when the band is inverted
    function automatic t_data clamp_to_band(input t_data raw);
        t_data v;
        v = raw;
        if (v >= band_top)
            v = band_top;
        if (v <= band_bottom)
            v = band_bottom;
        return v;
    endfunction

    // store one clamped pair, then return clamped values or the truncated window means
    function automatic t_sensor_result predict_result(input t_data left_raw, input t_data right_raw,
                                                      input t_data mag_l, input t_data mag_r);
        t_data          l_clamped;
        t_data          r_clamped;
        logic [31:0]    l_sum;
        logic [31:0]    r_sum;
        t_sensor_result res;
        l_clamped = clamp_to_band(left_raw);
        r_clamped = clamp_to_band(right_raw);
        left_ring[ring_slot]  = l_clamped;
        right_ring[ring_slot] = r_clamped;
        ring_slot = (ring_slot + 1 >= WINDOW_DEPTH) ? 0 : ring_slot + 1;
        if (fill_count < WINDOW_DEPTH)
            fill_count = fill_count + 1;

        if (fill_count >= WINDOW_DEPTH) begin
            l_sum = '0;
            r_sum = '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                l_sum = l_sum + left_ring[i];
                r_sum = r_sum + right_ring[i];
            end
            res.dist_left  = t_data'(l_sum / WINDOW_DEPTH);
            res.dist_right = t_data'(r_sum / WINDOW_DEPTH);
            res.averaged   = 1'b1;
        end else begin
            res.dist_left  = l_clamped;
            res.dist_right = r_clamped;
            res.averaged   = 1'b0;
        end

        // magnitude and sign flag; the most negative reading gives 32768
        res.mag_left_outside  = mag_l[DATA_W-1];
        res.mag_left_level    = mag_l[DATA_W-1] ? t_data'(~mag_l + 16'd1) : mag_l;
        res.mag_right_outside = mag_r[DATA_W-1];
        res.mag_right_level   = mag_r[DATA_W-1] ? t_data'(~mag_r + 16'd1) : mag_r;
        return res;
    endfunction

    task automatic compare_field(input string name, input t_data want, input t_data got);
        if (want !== got) begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // one pass per clock: register writes, result compare, then new expectation
    always @(posedge i_clk) begin
        t_sensor_result got;
        t_sensor_result want;
        if (!i_rst_n) begin
            band_top    = CLAMP_TOP_RST;
            band_bottom = CLAMP_BOTTOM_RST;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                left_ring[i]  = '0;
                right_ring[i] = '0;
            end
            ring_slot  = 0;
            fill_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CLAMP_TOP: begin
                        band_top = i_cfg_data;
                    end
                    REG_CLAMP_BOTTOM: begin
                        band_bottom = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if ($isunknown(i_out_valid) || $isunknown(i_in_stall)) begin
                mismatches = mismatches + 1;
                $display("%0t: handshake unknown, expected 0 or 1, got valid %b stall %b",
                         $time, i_out_valid, i_in_stall);
            end

            // result transfer
            if (i_out_valid && !i_out_stall) begin
                got.dist_left         = i_dist_left_mm;
                got.dist_right        = i_dist_right_mm;
                got.averaged          = i_averaged;
                got.mag_left_level    = i_mag_left_level;
                got.mag_left_outside  = i_mag_left_outside;
                got.mag_right_level   = i_mag_right_level;
                got.mag_right_outside = i_mag_right_outside;
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("dist_left_mm", want.dist_left, got.dist_left);
                    compare_field("dist_right_mm", want.dist_right, got.dist_right);
                    compare_field("averaged", t_data'(want.averaged), t_data'(got.averaged));
                    compare_field("mag_left_level", want.mag_left_level, got.mag_left_level);
                    compare_field("mag_left_outside", t_data'(want.mag_left_outside),
                                  t_data'(got.mag_left_outside));
                    compare_field("mag_right_level", want.mag_right_level, got.mag_right_level);
                    compare_field("mag_right_outside", t_data'(want.mag_right_outside),
                                  t_data'(got.mag_right_outside));
                end
            end

            // sample transfer
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_result(i_sonar_left_mm, i_sonar_right_mm,
                                                          i_mag_left, i_mag_right));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- test/tb_range_sensor_window_average.sv -----
// testbench top for range_sensor_window_average: stimulus, idling and verdict
module tb_range_sensor_window_average
    import rswa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_index;
    t_data    i_cfg_data;
    logic     i_valid;
    logic     o_stall;
    t_data    i_sonar_left_mm;
    t_data    i_sonar_right_mm;
    t_data    i_mag_left;
    t_data    i_mag_right;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_data    o_dist_left_mm;
    t_data    o_dist_right_mm;
    logic     o_averaged;
    t_data    o_mag_left_level;
    logic     o_mag_left_outside;
    t_data    o_mag_right_level;
    logic     o_mag_right_outside;

    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    logic     gaps_on = 1'b0;
    int       out_hold = 0;
    t_data    band_top_now;
    t_data    band_bottom_now;

    range_sensor_window_average dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sonar_left_mm     (i_sonar_left_mm),
        .i_sonar_right_mm    (i_sonar_right_mm),
        .i_mag_left          (i_mag_left),
        .i_mag_right         (i_mag_right),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_dist_left_mm      (o_dist_left_mm),
        .o_dist_right_mm     (o_dist_right_mm),
        .o_averaged          (o_averaged),
        .o_mag_left_level    (o_mag_left_level),
        .o_mag_left_outside  (o_mag_left_outside),
        .o_mag_right_level   (o_mag_right_level),
        .o_mag_right_outside (o_mag_right_outside)
    );

    range_sensor_window_average_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_valid),
        .i_in_stall          (o_stall),
        .i_sonar_left_mm     (i_sonar_left_mm),
        .i_sonar_right_mm    (i_sonar_right_mm),
        .i_mag_left          (i_mag_left),
        .i_mag_right         (i_mag_right),
        .i_out_valid         (o_valid),
        .i_out_stall         (i_stall),
        .i_dist_left_mm      (o_dist_left_mm),
        .i_dist_right_mm     (o_dist_right_mm),
        .i_averaged          (o_averaged),
        .i_mag_left_level    (o_mag_left_level),
        .i_mag_left_outside  (o_mag_left_outside),
        .i_mag_right_level   (o_mag_right_level),
        .i_mag_right_outside (o_mag_right_outside),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_range_sensor_window_average NOT OK");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (gaps_on && out_hold == 0 && $urandom_range(0, 5) == 0)
            out_hold = $urandom_range(1, 7);
        if (out_hold > 0) begin
            i_stall  <= 1'b1;
            out_hold = out_hold - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // one sample transfer, with an optional gap before it; returns at the accepting edge
    task automatic send_reading(input t_data left_mm, input t_data right_mm,
                                input t_data mag_l, input t_data mag_r);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sonar_left_mm  <= left_mm;
        i_sonar_right_mm <= right_mm;
        i_mag_left       <= mag_l;
        i_mag_right      <= mag_r;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // write both band registers while the block is idle
    task automatic set_band(input t_data top_mm, input t_data bottom_mm);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_CLAMP_TOP;
        i_cfg_data  <= top_mm;
        @(posedge i_clk);
        i_cfg_index <= REG_CLAMP_BOTTOM;
        i_cfg_data  <= bottom_mm;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        band_top_now    = top_mm;
        band_bottom_now = bottom_mm;
    endtask

    // distances aimed at the band edges, the field extremes, or anywhere
    function automatic t_data pick_distance();
        case ($urandom_range(0, 6))
            0: return t_data'(band_top_now + $urandom_range(0, 6) - 3);
            1: return t_data'(band_bottom_now + $urandom_range(0, 6) - 3);
            2: return '0;
            3: return '1;
            4: return t_data'($urandom_range(band_bottom_now, band_top_now));
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic t_data pick_mag();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_reading(pick_distance(), pick_distance(), pick_mag(), pick_mag());
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = REG_CLAMP_TOP;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_sonar_left_mm  = '0;
        i_sonar_right_mm = '0;
        i_mag_left       = '0;
        i_mag_right      = '0;
        band_top_now     = CLAMP_TOP_RST;
        band_bottom_now  = CLAMP_BOTTOM_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset band: limits, one past them, sign extremes; eighth transfer starts averaging
        gaps_on <= 1'b1;
        send_reading(16'd0, 16'd65535, 16'h0000, 16'hFFFF);
        send_reading(16'd65535, 16'd0, 16'h8000, 16'h7FFF);
        send_reading(16'd4000, 16'd20, 16'h0001, 16'h8001);
        send_reading(16'd3999, 16'd21, 16'h7FFF, 16'h8000);
        send_reading(16'd4001, 16'd19, 16'h0000, 16'h0000);
        send_reading(16'd20, 16'd4000, 16'hFFFF, 16'h0001);
        send_reading(16'd21, 16'd3999, 16'h1234, 16'hEDCC);
        send_reading(16'd2000, 16'd100, 16'h8000, 16'h8000);
        send_reading(16'd65535, 16'd0, 16'h7FFF, 16'h7FFF);
        send_random(240);
        drain();

        // widest band, every distance passes
        set_band(16'd65535, 16'd0);
        send_reading(16'd0, 16'd65535, 16'h0000, 16'hFFFF);
        send_reading(16'd65535, 16'd0, 16'h8000, 16'h7FFF);
        send_reading(16'd1, 16'd65534, 16'h0001, 16'hFFFE);
        send_random(250);
        drain();

        // zero-width band at zero, run without idling
        gaps_on <= 1'b0;
        set_band(16'd0, 16'd0);
        send_reading(16'd0, 16'd65535, 16'hAAAA, 16'h5555);
        send_reading(16'd12345, 16'd1, 16'h5555, 16'hAAAA);
        send_random(60);
        drain();

        // bottom above top: the bottom wins
        gaps_on <= 1'b1;
        set_band(16'd100, 16'd5000);
        send_reading(16'd0, 16'd65535, 16'h0000, 16'h8000);
        send_reading(16'd100, 16'd5000, 16'h7FFF, 16'hFFFF);
        send_reading(16'd4999, 16'd101, 16'h8001, 16'h0001);
        send_random(100);
        drain();

        // random ordered bands
        for (int p = 0; p < 4; p++) begin
            set_band(t_data'($urandom_range(32768, 65535)), t_data'($urandom_range(0, 32767)));
            send_random(75);
            drain();
        end

        // fully random registers, inversions allowed
        for (int p = 0; p < 2; p++) begin
            set_band(t_data'($urandom), t_data'($urandom));
            send_random(60);
            drain();
        end

        // bottom at its maximum over a top of one
        set_band(16'd1, 16'd65535);
        send_random(40);
        drain();

        // last stretch without idling on either side
        gaps_on <= 1'b0;
        set_band(16'd4000, 16'd20);
        send_random(300);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_range_sensor_window_average OK");
        end else begin
            $display("tb_range_sensor_window_average NOT OK");
        end
        $finish;
    end

endmodule
